/* design/gfenc_pkg.sv */
// ----------------------------------------------------------------------------
// gfenc_pkg
// Shared widths, codes and the control bundle of the GF(2^8) shard encoder.
// ----------------------------------------------------------------------------
package gfenc_pkg;

   localparam int MAX_INPUTS  = 32;
   localparam int MAX_OUTPUTS = 16;

   localparam int BYTE_W  = 8;
   localparam int SHARD_W = 5;
   localparam int ROW_W   = 4;
   localparam int NIN_W   = 6;
   localparam int NOUT_W  = 5;
   localparam int COEF_AW = $clog2(MAX_INPUTS);

   localparam logic [BYTE_W-1:0] POLY_RESET = 8'h1D;

   typedef enum logic {
      OP_COEF = 1'b0,
      OP_DATA = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_INPUT_COUNT  = 2'd0,
      REG_OUTPUT_COUNT = 2'd1,
      REG_FIELD_POLY   = 2'd2
   } reg_index_type;

   // Control bundle handed to every cell of the row.
   typedef struct packed {
      logic                ram_we;
      logic                ram_re;
      logic [COEF_AW-1:0]  addr;
      logic [BYTE_W-1:0]   wr_data;
      logic [BYTE_W-1:0]   mul_value;
      logic [BYTE_W-1:0]   poly;
      logic                update;
      logic                start;
      logic                load_out;
      logic                shift;
   } cell_ctrl_type;

endpackage

/* design/gfenc_ram.sv */
// ----------------------------------------------------------------------------
// gfenc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gfenc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wr_data;
      end
      if (re) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/gfenc_cell.sv */
// ----------------------------------------------------------------------------
// gfenc_cell
// One output row: its column of coefficients, its accumulator and one stage
// of the result shift chain.
// ----------------------------------------------------------------------------
module gfenc_cell (
   input  logic                           clock,
   input  gfenc_pkg::cell_ctrl_type       ctrl,
   input  logic [gfenc_pkg::BYTE_W-1:0]   shift_in,
   output logic [gfenc_pkg::BYTE_W-1:0]   shift_out
);

   // Carry-less multiply, reduced after each doubling.
   function automatic logic [gfenc_pkg::BYTE_W-1:0] gf_mul(
      input logic [gfenc_pkg::BYTE_W-1:0] a,
      input logic [gfenc_pkg::BYTE_W-1:0] b,
      input logic [gfenc_pkg::BYTE_W-1:0] poly
   );
      logic [gfenc_pkg::BYTE_W-1:0] acc;
      logic [gfenc_pkg::BYTE_W-1:0] sh;
      begin
         acc = '0;
         sh  = a;
         for (int k = 0; k < gfenc_pkg::BYTE_W; k++) begin
            if (b[k]) begin
               acc = acc ^ sh;
            end
            if (sh[gfenc_pkg::BYTE_W-1]) begin
               sh = {sh[gfenc_pkg::BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
               sh = {sh[gfenc_pkg::BYTE_W-2:0], 1'b0};
            end
         end
         return acc;
      end
   endfunction

   logic [gfenc_pkg::BYTE_W-1:0] coef;
   logic [gfenc_pkg::BYTE_W-1:0] prod;
   logic [gfenc_pkg::BYTE_W-1:0] acc_ff, acc_in;
   logic [gfenc_pkg::BYTE_W-1:0] out_ff, out_in;

   gfenc_ram #(
      .WIDTH (gfenc_pkg::BYTE_W),
      .DEPTH (gfenc_pkg::MAX_INPUTS)
   ) u_coef_ram (
      .clock   (clock),
      .we      (ctrl.ram_we),
      .re      (ctrl.ram_re),
      .addr    (ctrl.addr),
      .wr_data (ctrl.wr_data),
      .rd_data (coef)
   );

   assign prod = gf_mul(coef, ctrl.mul_value, ctrl.poly);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.update) begin
         acc_in = ctrl.start ? prod : (acc_ff ^ prod);
      end
   end

   // The burst is loaded only into an empty chain, so load and shift never meet.
   always_comb begin
      out_in = out_ff;
      if (ctrl.load_out) begin
         out_in = acc_in;
      end else if (ctrl.shift) begin
         out_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      out_ff <= out_in;
   end

   assign shift_out = out_ff;

endmodule

/* design/gf256_matrix_shard_encoder.sv */
// ----------------------------------------------------------------------------
// gf256_matrix_shard_encoder
// Reed-Solomon style matrix multiply over GF(2^8), one cell per output row.
// ----------------------------------------------------------------------------
//
//  channel  direction  tdata / data                          sideband
//  req      in         [4:0] in_shard [8:5] out_row          tuser: operation
//                      [16:9] value, zero padded to 24 bits
//  rsp      out        [3:0] out_index [11:4] out_byte       tlast: last
//                      zero padded to 16 bits
//  csr      in         csr_index (register), csr_data        write only
//
// A coefficient load is written when accepted. For a data byte, the request
// cycle reads each cell's coefficient RAM while the byte enters the update
// stage; from there the multiply and accumulate runs at once in all cells of
// rows in use. On the last input shard the results leave a shift chain at one
// per cycle when rsp_tready is high, while later requests keep being taken.
// A last-shard byte that finds the chain still draining waits in the update
// stage until the previous burst has been taken. Reset is synchronous; it
// clears the control state and sets the configuration registers to their
// defaults, with no clearing pass. Coefficients read as garbage until loaded.
//
module gf256_matrix_shard_encoder (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_shard[4:0], out_row[8:5], value[16:9]
   input  logic        req_tuser,   // operation[0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_index[3:0], out_byte[11:4]
   output logic        rsp_tlast,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int NCELL = gfenc_pkg::MAX_OUTPUTS;

   // Request fields.
   logic [gfenc_pkg::SHARD_W-1:0] req_shard;
   logic [gfenc_pkg::ROW_W-1:0]   req_row;
   logic [gfenc_pkg::BYTE_W-1:0]  req_value;
   gfenc_pkg::op_type             req_op;

   assign req_shard = req_tdata[4:0];
   assign req_row   = req_tdata[8:5];
   assign req_value = req_tdata[16:9];
   assign req_op    = gfenc_pkg::op_type'(req_tuser);

   // Configuration registers.
   logic [gfenc_pkg::NIN_W-1:0]  in_cnt_ff;
   logic [gfenc_pkg::NOUT_W-1:0] out_cnt_ff;
   logic [gfenc_pkg::BYTE_W-1:0] poly_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= gfenc_pkg::NIN_W'(1);
         out_cnt_ff <= gfenc_pkg::NOUT_W'(1);
         poly_ff    <= gfenc_pkg::POLY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (gfenc_pkg::reg_index_type'(csr_index))
            gfenc_pkg::REG_INPUT_COUNT:  in_cnt_ff  <= csr_data[gfenc_pkg::NIN_W-1:0];
            gfenc_pkg::REG_OUTPUT_COUNT: out_cnt_ff <= csr_data[gfenc_pkg::NOUT_W-1:0];
            gfenc_pkg::REG_FIELD_POLY:   poly_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Counts in use, clamped to the storage that exists.
   logic [gfenc_pkg::NIN_W-1:0]  nin;
   logic [gfenc_pkg::NOUT_W-1:0] nout;

   assign nin  = (in_cnt_ff > gfenc_pkg::NIN_W'(gfenc_pkg::MAX_INPUTS)) ?
                 gfenc_pkg::NIN_W'(gfenc_pkg::MAX_INPUTS) : in_cnt_ff;
   assign nout = (out_cnt_ff > gfenc_pkg::NOUT_W'(gfenc_pkg::MAX_OUTPUTS)) ?
                 gfenc_pkg::NOUT_W'(gfenc_pkg::MAX_OUTPUTS) : out_cnt_ff;

   // Request decode.
   logic accept;
   logic is_coef;
   logic is_data;
   logic data_emit;

   assign accept    = req_tvalid && req_tready;
   assign is_coef   = accept && (req_op == gfenc_pkg::OP_COEF);
   assign is_data   = accept && (req_op == gfenc_pkg::OP_DATA) &&
                      ({1'b0, req_shard} < nin);
   assign data_emit = (gfenc_pkg::NIN_W'({1'b0, req_shard}) + gfenc_pkg::NIN_W'(1)) == nin;

   // Update stage: holds a data byte while the cells read its coefficients.
   logic                         stg_valid_ff, stg_valid_in;
   logic                         stg_start_ff;
   logic                         stg_emit_ff;
   logic [gfenc_pkg::BYTE_W-1:0] stg_value_ff;

   // Result burst state.
   logic [gfenc_pkg::NOUT_W-1:0] remain_ff, remain_in;
   logic [gfenc_pkg::ROW_W-1:0]  idx_ff, idx_in;
   logic                         chain_busy;
   logic                         fire;
   logic                         rsp_take;

   assign chain_busy = (remain_ff != '0);
   assign fire       = stg_valid_ff && !(stg_emit_ff && chain_busy);
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign req_tready = !stg_valid_ff;

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (fire) begin
         stg_valid_in = 1'b0;
      end
      if (is_data) begin
         stg_valid_in = 1'b1;
      end
   end

   always_comb begin
      remain_in = remain_ff;
      idx_in    = idx_ff;
      if (fire && stg_emit_ff) begin
         remain_in = nout;
         idx_in    = '0;
      end else if (rsp_take) begin
         remain_in = remain_ff - gfenc_pkg::NOUT_W'(1);
         idx_in    = idx_ff + gfenc_pkg::ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         remain_ff    <= '0;
         idx_ff       <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         remain_ff    <= remain_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_data) begin
         stg_start_ff <= (req_shard == '0);
         stg_emit_ff  <= data_emit;
         stg_value_ff <= req_value;
      end
   end

   // Row of cells; results shift toward cell 0, which drives the output.
   gfenc_pkg::cell_ctrl_type     cell_ctrl [NCELL];
   logic [gfenc_pkg::BYTE_W-1:0] chain [NCELL+1];

   assign chain[NCELL] = '0;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      logic row_on;

      assign row_on = (gfenc_pkg::NOUT_W'(i) < nout);

      assign cell_ctrl[i].ram_we    = is_coef && (req_row == gfenc_pkg::ROW_W'(i));
      assign cell_ctrl[i].ram_re    = is_data;
      assign cell_ctrl[i].addr      = req_shard;
      assign cell_ctrl[i].wr_data   = req_value;
      assign cell_ctrl[i].mul_value = stg_value_ff;
      assign cell_ctrl[i].poly      = poly_ff;
      assign cell_ctrl[i].update    = fire && row_on;
      assign cell_ctrl[i].start     = stg_start_ff;
      assign cell_ctrl[i].load_out  = fire && stg_emit_ff && row_on;
      assign cell_ctrl[i].shift     = rsp_take;

      gfenc_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .shift_in  (chain[i+1]),
         .shift_out (chain[i])
      );
   end

   assign rsp_tvalid = chain_busy;
   assign rsp_tlast  = (remain_ff == gfenc_pkg::NOUT_W'(1));
   assign rsp_tdata  = {4'b0000, chain[0], idx_ff};

endmodule

/* design/gfenc_checker.sv */
// ----------------------------------------------------------------------------
// gfenc_checker
// Port-level checks on the result bursts of the shard encoder.
// ----------------------------------------------------------------------------
module gfenc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Within a burst the rows follow one another without a gap.
   a_rsp_next_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[3:0] == $past(rsp_tdata[3:0]) + 4'd1))
      else $error("burst row sequence broken");

   // A new burst opens at row zero.
   a_rsp_first_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> rsp_tdata[3:0] == 4'd0)
      else $error("burst does not start at row zero");

   // The cycle after the last row is taken the output is empty.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("result after end of burst");

   // Nothing is offered right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind gf256_matrix_shard_encoder gfenc_checker u_gfenc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
